// ===== sv/fprs_pkg.sv =====
// ----------------------------------------------------------------------------
// fprs_pkg
// Shared widths, codes and types for the fixed radius point search block.
// ----------------------------------------------------------------------------
package fprs_pkg;

    // Capacity of the point list
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int COORD_W    = 24;
    localparam int RAD_W      = 23;
    localparam int INDEX_W    = 6;
    localparam int ENTRY_W    = 2 * COORD_W;

    // Arithmetic widths: difference, square, sum of squares, radius squared
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int R2_W       = 2 * RAD_W;

    // Stream widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 56;

    // Action codes carried in the input tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Candidate leaving the distance pipeline
    typedef struct packed {
        logic                      valid;
        logic                      hit;
        logic [ADDR_W-1:0]         idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_cand;

endpackage

// ===== sv/fixed_radius_point_search_2d.sv =====
// ----------------------------------------------------------------------------
// fixed_radius_point_search_2d
// Brute force fixed radius neighbor search over a list of 2D points.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects the action. A load transaction
// appends one Q12.12 point to the list (restart empties it first); a load
// into a full list is dropped and a load gives no output. A query
// transaction brings an origin, a radius and the any_only flag.
// Output stream (m_axis): one transaction per matching point in index order,
// tlast on the final one; a query with no match gives one transaction with
// found clear. With any_only set only the first match is sent.
// Throughput: loads are accepted back to back. A query scans the point memory
// one entry per cycle while the scan is not frozen (see below); the input is
// ready again in the same cycle that the final transaction is presented.
// The scan rate is set by the single read port of the point memory, and
// candidates pass through the three stage distance pipeline.
// The input is not ready while a query runs.
// When the receiver stalls, the scan freezes as a new match arrives while
// one sits in the output register and one more waits; it resumes on release.
// Reset empties the list and drops any query in progress; the point memory
// itself is not cleared.
// ----------------------------------------------------------------------------
module fixed_radius_point_search_2d (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] restart, [24:1] coord_x, [48:25] coord_y, [71:49] radius,
    // [72] any_only, [79:73] zero
    input  logic [fprs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] action
    input  logic                              s_axis_tuser,
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [5:0] index, [29:6] match_x, [53:30] match_y, [55:54] zero
    output logic [fprs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] found
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state                              r_state;
    logic [fprs_pkg::CNT_W-1:0]          r_cnt;
    logic [fprs_pkg::CNT_W-1:0]          r_iss;
    logic signed [fprs_pkg::COORD_W-1:0] r_ox;
    logic signed [fprs_pkg::COORD_W-1:0] r_oy;
    logic [fprs_pkg::R2_W-1:0]           r_r2;
    logic                                r_any;
    logic                                r_s1_v;
    logic [fprs_pkg::ADDR_W-1:0]         r_s1_idx;

    // Match held until it is known whether another follows
    logic                                r_pend_v;
    logic [fprs_pkg::ADDR_W-1:0]         r_pend_idx;
    logic signed [fprs_pkg::COORD_W-1:0] r_pend_x;
    logic signed [fprs_pkg::COORD_W-1:0] r_pend_y;

    // Output register
    logic                                r_out_v;
    logic                                r_out_found;
    logic                                r_out_last;
    logic [fprs_pkg::INDEX_W-1:0]        r_out_idx;
    logic signed [fprs_pkg::COORD_W-1:0] r_out_x;
    logic signed [fprs_pkg::COORD_W-1:0] r_out_y;

    // Input fields
    logic                                w_restart;
    logic signed [fprs_pkg::COORD_W-1:0] w_cx;
    logic signed [fprs_pkg::COORD_W-1:0] w_cy;
    logic [fprs_pkg::RAD_W-1:0]          w_rad;
    logic                                w_any;
    logic                                w_in_acc;
    logic                                w_load;
    logic [fprs_pkg::CNT_W-1:0]          w_base;
    logic                                w_we;
    logic [fprs_pkg::CNT_W-1:0]          n_cnt;

    // Scan control
    logic                                w_out_busy;
    logic                                w_out_load;
    logic                                w_iss_v;
    logic                                w_adv;
    logic                                w_hit;
    logic                                w_stop;
    logic                                w_done;
    logic [fprs_pkg::ENTRY_W-1:0]        w_rdata;
    fprs_pkg::t_cand                     w_cand;
    logic                                w_dist_busy;

    assign w_restart = s_axis_tdata[0];
    assign w_cx      = s_axis_tdata[24:1];
    assign w_cy      = s_axis_tdata[48:25];
    assign w_rad     = s_axis_tdata[71:49];
    assign w_any     = s_axis_tdata[72];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_load        = w_in_acc & (s_axis_tuser == fprs_pkg::ACT_LOAD);

    // Append position: zero on restart, dropped when the list is full
    assign w_base = w_restart ? '0 : r_cnt;
    assign w_we   = w_load & (w_base < fprs_pkg::CNT_W'(fprs_pkg::MAX_POINTS));
    assign n_cnt  = w_base + fprs_pkg::CNT_W'(1);

    // Freeze the scan when a new match has nowhere to go
    assign w_out_busy = r_out_v & ~m_axis_tready;
    assign w_hit      = w_cand.valid & w_cand.hit;
    assign w_adv      = ~(w_hit & r_pend_v & w_out_busy);
    assign w_iss_v    = (r_state == ST_SCAN) & (r_iss < r_cnt);
    assign w_stop     = (r_state == ST_SCAN) & w_adv & w_hit & r_any;
    assign w_done     = ~w_iss_v & ~r_s1_v & ~w_dist_busy;

    // Fill the output register on a released match or on closing the query
    assign w_out_load = ((r_state == ST_SCAN) & w_adv & w_hit & r_pend_v)
                      | ((r_state == ST_FINISH) & ~w_out_busy);

    fprs_ram #(
        .P_WIDTH (fprs_pkg::ENTRY_W),
        .P_DEPTH (fprs_pkg::MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_base[fprs_pkg::ADDR_W-1:0]),
        .i_wdata ({w_cy, w_cx}),
        .i_re    (w_adv),
        .i_raddr (r_iss[fprs_pkg::ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    fprs_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_flush (w_stop),
        .i_valid (r_s1_v),
        .i_idx   (r_s1_idx),
        .i_entry (w_rdata),
        .i_ox    (r_ox),
        .i_oy    (r_oy),
        .i_r2    (r_r2),
        .o_cand  (w_cand),
        .o_busy  (w_dist_busy)
    );

    // State machine, scan counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_iss    <= '0;
            r_s1_v   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            // Load the output, or drop it once the receiver takes it
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_we) begin
                        r_cnt <= n_cnt;
                    end
                    if (w_in_acc && s_axis_tuser == fprs_pkg::ACT_QUERY) begin
                        r_ox    <= w_cx;
                        r_oy    <= w_cy;
                        r_r2    <= w_rad * w_rad;
                        r_any   <= w_any;
                        r_iss   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_adv) begin
                        r_s1_v   <= w_iss_v & ~w_stop;
                        r_s1_idx <= r_iss[fprs_pkg::ADDR_W-1:0];
                        if (w_iss_v) begin
                            r_iss <= r_iss + fprs_pkg::CNT_W'(1);
                        end
                        if (w_hit) begin
                            // Release the held match; the new one takes its place
                            if (r_pend_v) begin
                                r_out_found <= 1'b1;
                                r_out_last  <= 1'b0;
                                r_out_idx   <= fprs_pkg::INDEX_W'(r_pend_idx);
                                r_out_x     <= r_pend_x;
                                r_out_y     <= r_pend_y;
                            end
                            r_pend_v   <= 1'b1;
                            r_pend_idx <= w_cand.idx;
                            r_pend_x   <= w_cand.x;
                            r_pend_y   <= w_cand.y;
                            if (r_any) begin
                                r_state <= ST_FINISH;
                            end
                        end else if (w_done) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    // Send the held match as the final one, or a miss
                    if (!w_out_busy) begin
                        r_out_found <= r_pend_v;
                        r_out_last  <= 1'b1;
                        r_out_idx   <= r_pend_v ? fprs_pkg::INDEX_W'(r_pend_idx) : '0;
                        r_out_x     <= r_pend_v ? r_pend_x : '0;
                        r_out_y     <= r_pend_v ? r_pend_y : '0;
                        r_pend_v    <= 1'b0;
                        r_s1_v      <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {2'b00, r_out_y, r_out_x, r_out_idx};

    // The list never grows beyond its capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= fprs_pkg::CNT_W'(fprs_pkg::MAX_POINTS))
        else $error("point count above capacity");

    // No candidate is left in flight between queries
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1_v && !w_dist_busy && !r_pend_v))
        else $error("scan pipeline not empty in idle");

    // Closing a query always presents a final result
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && !w_out_busy) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("query closed without a final result");

    // A frozen scan keeps its read position
    a_freeze_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && !w_adv) |=> $stable(r_iss))
        else $error("scan position moved while frozen");

endmodule

// ===== sv/fprs_ram.sv =====
// ----------------------------------------------------------------------------
// fprs_ram
// Generic simple dual port RAM: one write port, one registered read port
// whose output holds while the read enable is low.
// ----------------------------------------------------------------------------
module fprs_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]                           i_wdata,
    input  logic                                         i_re,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]                           o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== sv/fprs_dist.sv =====
// ----------------------------------------------------------------------------
// fprs_dist
// Three stage distance check: difference, squares, sum and compare against
// the squared radius. All stages hold while the enable is low; a flush clears the valid bits.
// ----------------------------------------------------------------------------
module fprs_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_flush,
    input  logic                                 i_valid,
    input  logic [fprs_pkg::ADDR_W-1:0]          i_idx,
    input  logic [fprs_pkg::ENTRY_W-1:0]         i_entry,
    input  logic signed [fprs_pkg::COORD_W-1:0]  i_ox,
    input  logic signed [fprs_pkg::COORD_W-1:0]  i_oy,
    input  logic [fprs_pkg::R2_W-1:0]            i_r2,
    output fprs_pkg::t_cand                      o_cand,
    output logic                                 o_busy
);

    logic signed [fprs_pkg::COORD_W-1:0] w_px;
    logic signed [fprs_pkg::COORD_W-1:0] w_py;

    // Stage A: differences
    logic                                r_a_v;
    logic [fprs_pkg::ADDR_W-1:0]         r_a_idx;
    logic signed [fprs_pkg::COORD_W-1:0] r_a_x;
    logic signed [fprs_pkg::COORD_W-1:0] r_a_y;
    logic signed [fprs_pkg::DIFF_W-1:0]  r_a_dx;
    logic signed [fprs_pkg::DIFF_W-1:0]  r_a_dy;

    // Stage B: squares
    logic                                r_b_v;
    logic [fprs_pkg::ADDR_W-1:0]         r_b_idx;
    logic signed [fprs_pkg::COORD_W-1:0] r_b_x;
    logic signed [fprs_pkg::COORD_W-1:0] r_b_y;
    logic signed [fprs_pkg::SQ_W-1:0]    r_b_dx2;
    logic signed [fprs_pkg::SQ_W-1:0]    r_b_dy2;

    // Stage C: compare result
    logic [fprs_pkg::SUM_W-1:0]          w_d2;
    logic                                r_c_v;
    logic                                r_c_hit;
    logic [fprs_pkg::ADDR_W-1:0]         r_c_idx;
    logic signed [fprs_pkg::COORD_W-1:0] r_c_x;
    logic signed [fprs_pkg::COORD_W-1:0] r_c_y;

    assign w_py = i_entry[fprs_pkg::ENTRY_W-1:fprs_pkg::COORD_W];
    assign w_px = i_entry[fprs_pkg::COORD_W-1:0];

    // Squares are never negative, so the sum is taken unsigned
    assign w_d2 = {1'b0, r_b_dx2[fprs_pkg::SQ_W-1:0]}
                + {1'b0, r_b_dy2[fprs_pkg::SQ_W-1:0]};

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_idx <= i_idx;
            r_a_x   <= w_px;
            r_a_y   <= w_py;
            r_a_dx  <= {w_px[fprs_pkg::COORD_W-1], w_px} - {i_ox[fprs_pkg::COORD_W-1], i_ox};
            r_a_dy  <= {w_py[fprs_pkg::COORD_W-1], w_py} - {i_oy[fprs_pkg::COORD_W-1], i_oy};

            r_b_idx <= r_a_idx;
            r_b_x   <= r_a_x;
            r_b_y   <= r_a_y;
            r_b_dx2 <= r_a_dx * r_a_dx;
            r_b_dy2 <= r_a_dy * r_a_dy;

            r_c_idx <= r_b_idx;
            r_c_x   <= r_b_x;
            r_c_y   <= r_b_y;
            r_c_hit <= (w_d2 <= {{(fprs_pkg::SUM_W - fprs_pkg::R2_W){1'b0}}, i_r2});
        end
    end

    assign o_cand = {r_c_v, r_c_hit, r_c_idx, r_c_x, r_c_y};
    assign o_busy = r_a_v | r_b_v | r_c_v;

endmodule
